// ----- rtl/core/rfs_pkg.sv -----
// Shared types, codes and reset constants of the rocket flight sequencer.
package rfs_pkg;

	// Flight phase, one-hot inside the sequencer.
	typedef enum logic [9:0] {
		PH_INIT      = 10'b00_0000_0001,
		PH_GROUND    = 10'b00_0000_0010,
		PH_RISING    = 10'b00_0000_0100,
		PH_APOGEE    = 10'b00_0000_1000,
		PH_PARACHUTE = 10'b00_0001_0000,
		PH_DETACH    = 10'b00_0010_0000,
		PH_FALLING   = 10'b00_0100_0000,
		PH_DEPLOY    = 10'b00_1000_0000,
		PH_TOUCH     = 10'b01_0000_0000,
		PH_END       = 10'b10_0000_0000
	} phase_t;

	// Pending timed wait, one-hot.
	typedef enum logic [3:0] {
		WK_NONE    = 4'b0001,
		WK_CONFIRM = 4'b0010,
		WK_SETTLE  = 4'b0100,
		WK_HOLD    = 4'b1000
	} wait_t;

	// Phase codes as reported on the result stream.
	localparam logic [3:0] PHASE_CODE_INIT      = 4'd0;
	localparam logic [3:0] PHASE_CODE_GROUND    = 4'd1;
	localparam logic [3:0] PHASE_CODE_RISING    = 4'd2;
	localparam logic [3:0] PHASE_CODE_APOGEE    = 4'd3;
	localparam logic [3:0] PHASE_CODE_PARACHUTE = 4'd4;
	localparam logic [3:0] PHASE_CODE_DETACH    = 4'd5;
	localparam logic [3:0] PHASE_CODE_FALLING   = 4'd6;
	localparam logic [3:0] PHASE_CODE_DEPLOY    = 4'd7;
	localparam logic [3:0] PHASE_CODE_TOUCH     = 4'd8;
	localparam logic [3:0] PHASE_CODE_END       = 4'd9;

	// Configuration register indexes.
	localparam logic [2:0] REG_LAUNCH_ALT   = 3'd0;
	localparam logic [2:0] REG_DEPLOY_ALT   = 3'd1;
	localparam logic [2:0] REG_ABORT_START  = 3'd2;
	localparam logic [2:0] REG_APOGEE_TIME  = 3'd3;
	localparam logic [2:0] REG_END_TIME     = 3'd4;
	localparam logic [2:0] REG_CONFIRM_DLY  = 3'd5;
	localparam logic [2:0] REG_SETTLE_DLY   = 3'd6;
	localparam logic [2:0] REG_SERVO_HOLD   = 3'd7;

	// Register reset values.
	localparam int RST_LAUNCH_ALT  = 200;
	localparam int RST_DEPLOY_ALT  = 1250;
	localparam int RST_ABORT_START = 3000;
	localparam int RST_APOGEE_TIME = 30000;
	localparam int RST_END_TIME    = 600 * 1000;
	localparam int RST_CONFIRM_DLY = 100;
	localparam int RST_SETTLE_DLY  = 3000;
	localparam int RST_SERVO_HOLD  = 1000;

	function automatic logic [3:0] phase_code(input phase_t ph);
		logic [3:0] code;
		unique case (ph)
			PH_INIT:      code = PHASE_CODE_INIT;
			PH_GROUND:    code = PHASE_CODE_GROUND;
			PH_RISING:    code = PHASE_CODE_RISING;
			PH_APOGEE:    code = PHASE_CODE_APOGEE;
			PH_PARACHUTE: code = PHASE_CODE_PARACHUTE;
			PH_DETACH:    code = PHASE_CODE_DETACH;
			PH_FALLING:   code = PHASE_CODE_FALLING;
			PH_DEPLOY:    code = PHASE_CODE_DEPLOY;
			PH_TOUCH:     code = PHASE_CODE_TOUCH;
			PH_END:       code = PHASE_CODE_END;
			default:      code = PHASE_CODE_INIT;
		endcase
		return code;
	endfunction

endpackage

// ----- rtl/core/rfs_regs.sv -----
// APB configuration register file of the rocket flight sequencer.
module rfs_regs #(
	parameter int TIME_BITS = 32,
	parameter int ALT_BITS  = 20,
	localparam int DATA_W   = (TIME_BITS > 32) ? 64 : 32,
	localparam int SHIFT    = (TIME_BITS > 32) ? 3 : 2,
	localparam int ADDR_W   = SHIFT + 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ADDR_W-1:0]           paddr,
	input  logic [DATA_W-1:0]           pwdata,
	output logic [DATA_W-1:0]           prdata,
	output logic                        pready,
	output logic signed [ALT_BITS-1:0]  launch_altitude,
	output logic signed [ALT_BITS-1:0]  deploy_altitude,
	output logic [TIME_BITS-1:0]        abort_window_start,
	output logic [TIME_BITS-1:0]        apogee_time,
	output logic [TIME_BITS-1:0]        end_time,
	output logic [TIME_BITS-1:0]        confirm_delay,
	output logic [TIME_BITS-1:0]        settle_delay,
	output logic [TIME_BITS-1:0]        servo_hold
);
	import rfs_pkg::*;

	logic [2:0] idx;
	logic       wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:SHIFT];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_altitude    <= ALT_BITS'(RST_LAUNCH_ALT);
			deploy_altitude    <= ALT_BITS'(RST_DEPLOY_ALT);
			abort_window_start <= TIME_BITS'(RST_ABORT_START);
			apogee_time        <= TIME_BITS'(RST_APOGEE_TIME);
			end_time           <= TIME_BITS'(RST_END_TIME);
			confirm_delay      <= TIME_BITS'(RST_CONFIRM_DLY);
			settle_delay       <= TIME_BITS'(RST_SETTLE_DLY);
			servo_hold         <= TIME_BITS'(RST_SERVO_HOLD);
		end else if (wr_en) begin
			unique case (idx)
				REG_LAUNCH_ALT:  launch_altitude    <= pwdata[ALT_BITS-1:0];
				REG_DEPLOY_ALT:  deploy_altitude    <= pwdata[ALT_BITS-1:0];
				REG_ABORT_START: abort_window_start <= pwdata[TIME_BITS-1:0];
				REG_APOGEE_TIME: apogee_time        <= pwdata[TIME_BITS-1:0];
				REG_END_TIME:    end_time           <= pwdata[TIME_BITS-1:0];
				REG_CONFIRM_DLY: confirm_delay      <= pwdata[TIME_BITS-1:0];
				REG_SETTLE_DLY:  settle_delay       <= pwdata[TIME_BITS-1:0];
				REG_SERVO_HOLD:  servo_hold         <= pwdata[TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Altitude levels read back sign-extended.
	always_comb begin
		unique case (idx)
			REG_LAUNCH_ALT:  prdata = DATA_W'(launch_altitude);
			REG_DEPLOY_ALT:  prdata = DATA_W'(deploy_altitude);
			REG_ABORT_START: prdata = DATA_W'(abort_window_start);
			REG_APOGEE_TIME: prdata = DATA_W'(apogee_time);
			REG_END_TIME:    prdata = DATA_W'(end_time);
			REG_CONFIRM_DLY: prdata = DATA_W'(confirm_delay);
			REG_SETTLE_DLY:  prdata = DATA_W'(settle_delay);
			REG_SERVO_HOLD:  prdata = DATA_W'(servo_hold);
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- rtl/core/rfs_step.sv -----
// Input register, flight state machine and result register of the sequencer.
module rfs_step #(
	parameter int TIME_BITS = 32,
	parameter int ALT_BITS  = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [TIME_BITS-1:0]        now_ms,
	input  logic signed [ALT_BITS-1:0]  altitude_dm,
	input  logic                        detach_pin,
	input  logic signed [ALT_BITS-1:0]  launch_altitude,
	input  logic signed [ALT_BITS-1:0]  deploy_altitude,
	input  logic [TIME_BITS-1:0]        abort_window_start,
	input  logic [TIME_BITS-1:0]        apogee_time,
	input  logic [TIME_BITS-1:0]        end_time,
	input  logic [TIME_BITS-1:0]        confirm_delay,
	input  logic [TIME_BITS-1:0]        settle_delay,
	input  logic [TIME_BITS-1:0]        servo_hold,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [3:0]                  phase,
	output logic [TIME_BITS-1:0]        flight_ms,
	output logic                        fire1_n,
	output logic                        fire2_n,
	output logic                        servo_move
);
	import rfs_pkg::*;

	// Input stage.
	logic                       valid_s1;
	logic [TIME_BITS-1:0]       now_s1;
	logic signed [ALT_BITS-1:0] alt_s1;
	logic                       pin_s1;

	// Sequencer state.
	phase_t               phase_q, phase_d;
	wait_t                wait_q, wait_d;
	logic [TIME_BITS-1:0] launch_q, launch_d;
	logic [TIME_BITS-1:0] wstamp_q, wstamp_d;
	logic                 fire1_q, fire1_d;
	logic                 fire2_q, fire2_d;

	// Result stage.
	logic                 valid_s2;
	logic [3:0]           phase_s2;
	logic [TIME_BITS-1:0] flight_s2;
	logic                 servo_s2;

	logic                 advance;
	logic                 flown_now, flown_d, captured, servo_d;
	logic [TIME_BITS-1:0] since_launch, ft, waited, flight_d;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			now_s1 <= now_ms;
			alt_s1 <= altitude_dm;
			pin_s1 <= detach_pin;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		wait_d   = wait_q;
		launch_d = launch_q;
		wstamp_d = wstamp_q;
		fire1_d  = fire1_q;
		fire2_d  = fire2_q;
		servo_d  = 1'b0;
		captured = 1'b0;

		flown_now    = (phase_q != PH_INIT) && (phase_q != PH_GROUND);
		since_launch = now_s1 - launch_q;
		ft           = flown_now ? since_launch : '0;
		waited       = now_s1 - wstamp_q;

		unique case (phase_q)
			PH_INIT: phase_d = PH_GROUND;
			PH_GROUND: begin
				if (alt_s1 >= launch_altitude) begin
					phase_d  = PH_RISING;
					launch_d = now_s1;
					captured = 1'b1;
				end
			end
			PH_RISING: begin
				if (ft >= abort_window_start && ft < apogee_time) begin
					if (alt_s1 <= launch_altitude) begin
						phase_d = PH_GROUND;
					end
				end else if (ft >= apogee_time) begin
					phase_d = PH_APOGEE;
				end
			end
			PH_APOGEE: phase_d = PH_PARACHUTE;
			PH_PARACHUTE: begin
				fire1_d = 1'b0;
				phase_d = PH_DETACH;
			end
			PH_DETACH: begin
				unique case (wait_q)
					WK_CONFIRM: begin
						if (waited >= confirm_delay) begin
							if (pin_s1) begin
								wait_d   = WK_SETTLE;
								wstamp_d = now_s1;
							end else begin
								wait_d = WK_NONE;
							end
						end
					end
					WK_SETTLE: begin
						if (waited >= settle_delay) begin
							phase_d  = PH_FALLING;
							servo_d  = 1'b1;
							wait_d   = WK_HOLD;
							wstamp_d = now_s1;
						end
					end
					default: begin
						if (pin_s1) begin
							wait_d   = WK_CONFIRM;
							wstamp_d = now_s1;
						end
					end
				endcase
			end
			PH_FALLING: begin
				// Altitude is ignored until the servo hold has run out.
				if (!(wait_q == WK_HOLD && waited < servo_hold)) begin
					if (wait_q == WK_HOLD) begin
						wait_d = WK_NONE;
					end
					if (alt_s1 <= deploy_altitude) begin
						phase_d = PH_DEPLOY;
					end
				end
			end
			PH_DEPLOY: begin
				fire2_d = 1'b0;
				phase_d = PH_TOUCH;
			end
			PH_TOUCH: begin
				if (ft >= end_time) begin
					phase_d = PH_END;
				end
			end
			PH_END: ;
			default: ;
		endcase

		// A fresh launch stamp equals now, so the reported flight time is zero.
		flown_d  = (phase_d != PH_INIT) && (phase_d != PH_GROUND);
		flight_d = (flown_d && !captured) ? since_launch : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_INIT;
			wait_q   <= WK_NONE;
			launch_q <= '0;
			wstamp_q <= '0;
			fire1_q  <= 1'b1;
			fire2_q  <= 1'b1;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				phase_q  <= phase_d;
				wait_q   <= wait_d;
				launch_q <= launch_d;
				wstamp_q <= wstamp_d;
				fire1_q  <= fire1_d;
				fire2_q  <= fire2_d;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_s2  <= phase_code(phase_d);
			flight_s2 <= flight_d;
			servo_s2  <= servo_d;
		end
	end

	assign out_valid  = valid_s2;
	assign phase      = phase_s2;
	assign flight_ms  = flight_s2;
	assign fire1_n    = fire1_q;
	assign fire2_n    = fire2_q;
	assign servo_move = servo_s2;

endmodule

// ----- rtl/core/rocket_flight_sequencer_core.sv -----
// Top level of the rocket flight sequencer: stream ports, APB registers and the sequencer.
// Path: a tick item is captured in the input register, stepped by the flight state
// machine and held in the result register until the result side takes it.
// Throughput: one item per clock; the next-state step between the input register and
// the result register is combinational, and the rate holds while the result side
// stalls only as long as the result register is free or being taken.
// Reset (arst_n low, asynchronous): registers return to their defaults, the phase goes to
// init, both fire lines go high, no wait is pending and both pipeline stages empty.
module rocket_flight_sequencer_core #(
	parameter int TIME_BITS = 32,
	parameter int ALT_BITS  = 20,
	localparam int DATA_W   = (TIME_BITS > 32) ? 64 : 32,
	localparam int ADDR_W   = ((TIME_BITS > 32) ? 3 : 2) + 3,
	localparam int IN_W     = ((TIME_BITS + ALT_BITS + 1 + 7) / 8) * 8,
	localparam int OUT_W    = ((TIME_BITS + 7 + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// Tick items in. s_tdata from bit 0: now_ms, altitude_dm, detach_pin, zero fill.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,
	// Result items out. m_tdata from bit 0: phase, flight_ms, fire1_n, fire2_n,
	// servo_move, zero fill.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,
	// Configuration.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);
	import rfs_pkg::*;

	logic [TIME_BITS-1:0]       now_ms;
	logic signed [ALT_BITS-1:0] altitude_dm;
	logic                       detach_pin;

	logic signed [ALT_BITS-1:0] launch_altitude, deploy_altitude;
	logic [TIME_BITS-1:0]       abort_window_start, apogee_time, end_time;
	logic [TIME_BITS-1:0]       confirm_delay, settle_delay, servo_hold;

	logic [3:0]           phase;
	logic [TIME_BITS-1:0] flight_ms;
	logic                 fire1_n, fire2_n, servo_move;

	// Unpack the tick fields; the first field sits in the lowest bits.
	assign now_ms      = s_tdata[TIME_BITS-1:0];
	assign altitude_dm = s_tdata[TIME_BITS+ALT_BITS-1:TIME_BITS];
	assign detach_pin  = s_tdata[TIME_BITS+ALT_BITS];

	// Registers are to be written only while no tick is in flight (the user's duty; the block
	// does not enforce it), so the sequencer reads them directly with no shadow copy.
	rfs_regs #(
		.TIME_BITS(TIME_BITS),
		.ALT_BITS (ALT_BITS)
	) u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.launch_altitude   (launch_altitude),
		.deploy_altitude   (deploy_altitude),
		.abort_window_start(abort_window_start),
		.apogee_time       (apogee_time),
		.end_time          (end_time),
		.confirm_delay     (confirm_delay),
		.settle_delay      (settle_delay),
		.servo_hold        (servo_hold)
	);

	// The sequencer registers each tick, steps the flight state once per tick
	// and holds the result in an output register so the next tick can enter
	// while a result still waits.
	rfs_step #(
		.TIME_BITS(TIME_BITS),
		.ALT_BITS (ALT_BITS)
	) u_step (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (s_tvalid),
		.in_ready          (s_tready),
		.now_ms            (now_ms),
		.altitude_dm       (altitude_dm),
		.detach_pin        (detach_pin),
		.launch_altitude   (launch_altitude),
		.deploy_altitude   (deploy_altitude),
		.abort_window_start(abort_window_start),
		.apogee_time       (apogee_time),
		.end_time          (end_time),
		.confirm_delay     (confirm_delay),
		.settle_delay      (settle_delay),
		.servo_hold        (servo_hold),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.phase             (phase),
		.flight_ms         (flight_ms),
		.fire1_n           (fire1_n),
		.fire2_n           (fire2_n),
		.servo_move        (servo_move)
	);

	// Pack the result fields from the lowest bit up and zero-fill the top.
	assign m_tdata = OUT_W'({servo_move, fire2_n, fire1_n, flight_ms, phase});

endmodule

// ----- bench/tb_rocket_flight_sequencer_core.sv -----
// Self-checking bench for the rocket flight sequencer core: table-driven opening, random flights.
`timescale 1ns / 100ps

module tb_rocket_flight_sequencer_core;
	import rfs_pkg::*;

	// Stream widths at the default parameters: a tick item packs 32 + 20 + 1 bits into
	// seven bytes, a result item packs 4 + 32 + 3 bits into five bytes.
	localparam int IN_W       = 56;
	localparam int OUT_W      = 40;
	localparam int TICK_BITS  = 53;
	localparam int TELEM_BITS = 39;

	// The run is aborted if it has not ended after this many clocks.
	localparam int CYCLE_LIMIT = 200000;
	// Length of the one long result-side hold-off, and when it starts.
	localparam int LONG_HOLD     = 120;
	localparam int HOLD_AFTER    = 60;
	localparam int N_OPENING     = 16;
	localparam int DRAIN_CYCLES  = 10;

	localparam logic signed [19:0] ALT_MAX = 20'sh7FFFF;
	localparam logic signed [19:0] ALT_MIN = 20'sh80000;

	// One tick item; the first member sits in the highest bits of a packed struct, so
	// now lands in the lowest bits of s_tdata as the port layout asks.
	typedef struct packed {
		logic               pin;
		logic signed [19:0] alt;
		logic [31:0]        now;
	} tick_t;

	// One result item, laid out as m_tdata from bit 0 upward: phase, flight_ms, fire1_n,
	// fire2_n, servo_move.
	typedef struct packed {
		logic        servo_move;
		logic        fire2_n;
		logic        fire1_n;
		logic [31:0] flight_ms;
		logic [3:0]  phase;
	} telemetry_t;

	// A row of the opening stimulus. Rows with typed set carry a result worked out by
	// hand; the other rows are checked against the predictor.
	typedef struct packed {
		logic [31:0]        now;
		logic signed [19:0] alt;
		logic               pin;
		logic               typed;
		logic [3:0]         phase;
		logic [31:0]        flight_ms;
		logic               fire1_n;
		logic               fire2_n;
		logic               servo_move;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic            s_tvalid = 1'b0;
	logic            s_tready;
	// Fields from bit 0: now_ms, altitude_dm, detach_pin, zero fill.
	logic [IN_W-1:0] s_tdata = '0;

	logic             m_tvalid;
	logic             m_tready = 1'b0;
	// Fields from bit 0: phase, flight_ms, fire1_n, fire2_n, servo_move, zero fill.
	logic [OUT_W-1:0] m_tdata;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	rocket_flight_sequencer_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// Shadow copy of the register file, loaded with the reset values.
	logic signed [19:0] cfg_launch_alt  = 20'(RST_LAUNCH_ALT);
	logic signed [19:0] cfg_deploy_alt  = 20'(RST_DEPLOY_ALT);
	logic [31:0]        cfg_abort_start = RST_ABORT_START;
	logic [31:0]        cfg_apogee_time = RST_APOGEE_TIME;
	logic [31:0]        cfg_end_time    = RST_END_TIME;
	logic [31:0]        cfg_confirm_dly = RST_CONFIRM_DLY;
	logic [31:0]        cfg_settle_dly  = RST_SETTLE_DLY;
	logic [31:0]        cfg_servo_hold  = RST_SERVO_HOLD;

	// Predicted sequencer state, starting from the reset state.
	logic [3:0]  ph = PHASE_CODE_INIT;
	logic [31:0] launch_stamp = '0;
	logic [31:0] wait_stamp = '0;
	wait_t       wk = WK_NONE;
	logic        fire1 = 1'b1;
	logic        fire2 = 1'b1;

	// Results predicted but not yet seen on the master side, oldest first.
	telemetry_t telemetry_due[$];

	int errors = 0;
	int ticks_sent = 0;
	int results_checked = 0;
	int aborts_seen = 0;
	int servo_pulses = 0;
	int settings_used = 0;
	logic [3:0] deepest_phase = PHASE_CODE_INIT;

	// Knobs that shape the random flights of the current part of the run.
	logic [31:0] clock_ms = '0;
	int step_max = 10;
	int jump_pct = 0;
	bit jump_any = 1'b0;
	int confirm_pin_pct = 50;
	int burst_left = 1;

	// Advances the predicted sequencer by one tick and returns the telemetry it reports.
	// Decisions use the flight time as it stood before the tick; the reported flight
	// time uses the phase after it.
	function automatic telemetry_t sequencer_advance(input tick_t t);
		logic [31:0] flight_t;
		logic [31:0] waited;
		logic signed [19:0] alt;
		telemetry_t r;
		alt = t.alt;
		flight_t = (ph >= PHASE_CODE_RISING) ? t.now - launch_stamp : 32'd0;
		waited = t.now - wait_stamp;
		r.servo_move = 1'b0;
		case (ph)
			PHASE_CODE_INIT: ph = PHASE_CODE_GROUND;
			PHASE_CODE_GROUND: begin
				if (alt >= cfg_launch_alt) begin
					ph = PHASE_CODE_RISING;
					launch_stamp = t.now;
				end
			end
			PHASE_CODE_RISING: begin
				// With the window crossed the first branch never opens, so the
				// rocket only leaves rising at the apogee time.
				if (flight_t >= cfg_abort_start && flight_t < cfg_apogee_time) begin
					if (alt <= cfg_launch_alt) begin
						ph = PHASE_CODE_GROUND;
						aborts_seen++;
					end
				end else if (flight_t >= cfg_apogee_time) begin
					ph = PHASE_CODE_APOGEE;
				end
			end
			PHASE_CODE_APOGEE: ph = PHASE_CODE_PARACHUTE;
			PHASE_CODE_PARACHUTE: begin
				fire1 = 1'b0;
				ph = PHASE_CODE_DETACH;
			end
			PHASE_CODE_DETACH: begin
				case (wk)
					WK_CONFIRM: begin
						if (waited >= cfg_confirm_dly) begin
							if (t.pin) begin
								wk = WK_SETTLE;
								wait_stamp = t.now;
							end else begin
								wk = WK_NONE;
							end
						end
					end
					WK_SETTLE: begin
						if (waited >= cfg_settle_dly) begin
							ph = PHASE_CODE_FALLING;
							r.servo_move = 1'b1;
							wk = WK_HOLD;
							wait_stamp = t.now;
						end
					end
					default: begin
						if (t.pin) begin
							wk = WK_CONFIRM;
							wait_stamp = t.now;
						end
					end
				endcase
			end
			PHASE_CODE_FALLING: begin
				// Altitude is ignored until the servo hold has run out.
				if (!(wk == WK_HOLD && waited < cfg_servo_hold)) begin
					wk = WK_NONE;
					if (alt <= cfg_deploy_alt)
						ph = PHASE_CODE_DEPLOY;
				end
			end
			PHASE_CODE_DEPLOY: begin
				fire2 = 1'b0;
				ph = PHASE_CODE_TOUCH;
			end
			PHASE_CODE_TOUCH: begin
				if (flight_t >= cfg_end_time)
					ph = PHASE_CODE_END;
			end
			default: ;
		endcase
		r.phase = ph;
		r.flight_ms = (ph >= PHASE_CODE_RISING) ? t.now - launch_stamp : 32'd0;
		r.fire1_n = fire1;
		r.fire2_n = fire2;
		if (r.servo_move)
			servo_pulses++;
		if (ph > deepest_phase)
			deepest_phase = ph;
		return r;
	endfunction

	// Builds the next random tick from the predicted phase, so that most ticks sit
	// near the threshold that matters in that phase and the flight keeps moving.
	function automatic tick_t next_flight_tick();
		tick_t t;
		int base;
		int v;
		int roll;
		clock_ms = clock_ms + $urandom_range(step_max, 0);
		if ((jump_any || ph == PHASE_CODE_GROUND) && $urandom_range(99, 0) < jump_pct)
			clock_ms = $urandom();
		t.now = clock_ms;
		case (ph)
			PHASE_CODE_GROUND, PHASE_CODE_RISING: base = cfg_launch_alt;
			PHASE_CODE_FALLING: base = cfg_deploy_alt;
			default: base = 0;
		endcase
		roll = $urandom_range(99, 0);
		if (roll < 15) begin
			t.alt = 20'($urandom());
		end else if (roll < 25) begin
			t.alt = 20'(base);
		end else begin
			v = base + int'($urandom_range(120, 0)) - 40;
			if (v > int'(ALT_MAX))
				v = int'(ALT_MAX);
			if (v < int'(ALT_MIN))
				v = int'(ALT_MIN);
			t.alt = 20'(v);
		end
		// The pin level only decides anything in detach: it starts a confirm wait and is checked when that wait runs out.
		if (ph == PHASE_CODE_DETACH && wk == WK_CONFIRM)
			t.pin = ($urandom_range(99, 0) < confirm_pin_pct);
		else
			t.pin = 1'($urandom_range(1, 0));
		return t;
	endfunction

	// Offers one tick item and holds it until the block takes it. The sender works in
	// bursts: after each burst it idles for a random gap, sometimes none at all.
	task automatic send_tick(input tick_t t, input logic typed, input telemetry_t typed_exp);
		telemetry_t predicted;
		int gap;
		s_tdata <= {{(IN_W-TICK_BITS){1'b0}}, t};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = sequencer_advance(t);
		telemetry_due.push_back(typed ? typed_exp : predicted);
		ticks_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(24, 1);
			gap = ($urandom_range(99, 0) < 40) ? 0 : $urandom_range(6, 1);
			if ($urandom_range(99, 0) < 5)
				gap = 15;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Waits until the block has nothing in flight, so registers may be written.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (telemetry_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB write: a setup phase, then an access phase that ends on the edge where
	// pready is seen high. The shadow registers follow.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LAUNCH_ALT:  cfg_launch_alt = value[19:0];
			REG_DEPLOY_ALT:  cfg_deploy_alt = value[19:0];
			REG_ABORT_START: cfg_abort_start = value;
			REG_APOGEE_TIME: cfg_apogee_time = value;
			REG_END_TIME:    cfg_end_time = value;
			REG_CONFIRM_DLY: cfg_confirm_dly = value;
			REG_SETTLE_DLY:  cfg_settle_dly = value;
			REG_SERVO_HOLD:  cfg_servo_hold = value;
			default: ;
		endcase
	endtask

	// Drains the block and loads a complete register setting.
	task automatic load_setting(input int launch_alt, input int deploy_alt,
			input logic [31:0] abort_start, input logic [31:0] apogee_time,
			input logic [31:0] end_time, input logic [31:0] confirm_dly,
			input logic [31:0] settle_dly, input logic [31:0] servo_hold);
		quiesce();
		write_reg(REG_LAUNCH_ALT, launch_alt);
		write_reg(REG_DEPLOY_ALT, deploy_alt);
		write_reg(REG_ABORT_START, abort_start);
		write_reg(REG_APOGEE_TIME, apogee_time);
		write_reg(REG_END_TIME, end_time);
		write_reg(REG_CONFIRM_DLY, confirm_dly);
		write_reg(REG_SETTLE_DLY, settle_dly);
		write_reg(REG_SERVO_HOLD, servo_hold);
		settings_used++;
	endtask

	task automatic fly(input int count);
		repeat (count)
			send_tick(next_flight_tick(), 1'b0, '0);
	endtask

	// A delay that is zero half of the time, to hit the next-tick expiry of zero waits.
	function automatic logic [31:0] maybe_zero(input int hi);
		return ($urandom_range(1, 0) != 0) ? 32'd0 : 32'($urandom_range(hi, 1));
	endfunction

	// Opening rows, all under the reset register values. The sequencer can only pass
	// apogee once per reset, so these rows stay between ground and rising: the field
	// extremes, the launch level hit exactly, an abort right at the window start, an
	// abort one millisecond before apogee, and launches across the time wrap.
	row_t opening_rows [N_OPENING] = '{
		'{32'd0,          20'sd0,  1'b0, 1'b1, PHASE_CODE_GROUND, 32'd0, 1'b1, 1'b1, 1'b0},
		'{32'd10,         ALT_MIN, 1'b1, 1'b1, PHASE_CODE_GROUND, 32'd0, 1'b1, 1'b1, 1'b0},
		'{32'd20,         20'sd199, 1'b0, 1'b1, PHASE_CODE_GROUND, 32'd0, 1'b1, 1'b1, 1'b0},
		'{32'd30,         20'sd200, 1'b0, 1'b1, PHASE_CODE_RISING, 32'd0, 1'b1, 1'b1, 1'b0},
		'{32'd1000,       ALT_MAX, 1'b1, 1'b0, PHASE_CODE_INIT, 32'd0, 1'b0, 1'b0, 1'b0},
		'{32'd3029,       20'sd100, 1'b0, 1'b0, PHASE_CODE_INIT, 32'd0, 1'b0, 1'b0, 1'b0},
		'{32'd3030,       20'sd200, 1'b0, 1'b1, PHASE_CODE_GROUND, 32'd0, 1'b1, 1'b1, 1'b0},
		'{32'd3040,       ALT_MAX, 1'b0, 1'b0, PHASE_CODE_INIT, 32'd0, 1'b0, 1'b0, 1'b0},
		'{32'd3041,       ALT_MIN, 1'b1, 1'b0, PHASE_CODE_INIT, 32'd0, 1'b0, 1'b0, 1'b0},
		'{32'd33039,      20'sd201, 1'b0, 1'b0, PHASE_CODE_INIT, 32'd0, 1'b0, 1'b0, 1'b0},
		'{32'd33039,      20'sd200, 1'b0, 1'b1, PHASE_CODE_GROUND, 32'd0, 1'b1, 1'b1, 1'b0},
		'{32'hFFFF_FFF0,  ALT_MAX, 1'b0, 1'b0, PHASE_CODE_INIT, 32'd0, 1'b0, 1'b0, 1'b0},
		'{32'h0000_0010,  20'sd0,  1'b1, 1'b0, PHASE_CODE_INIT, 32'd0, 1'b0, 1'b0, 1'b0},
		'{32'h0000_0BC0,  ALT_MIN, 1'b0, 1'b1, PHASE_CODE_GROUND, 32'd0, 1'b1, 1'b1, 1'b0},
		'{32'hFFFF_FFFF,  ALT_MAX, 1'b1, 1'b0, PHASE_CODE_INIT, 32'd0, 1'b0, 1'b0, 1'b0},
		'{32'h0000_0000,  -20'sd1, 1'b0, 1'b0, PHASE_CODE_INIT, 32'd0, 1'b0, 1'b0, 1'b0}
	};

	initial begin : stimulus
		int k;
		tick_t t;
		telemetry_t hand;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_OPENING; k++) begin
			t.now = opening_rows[k].now;
			t.alt = opening_rows[k].alt;
			t.pin = opening_rows[k].pin;
			hand.phase = opening_rows[k].phase;
			hand.flight_ms = opening_rows[k].flight_ms;
			hand.fire1_n = opening_rows[k].fire1_n;
			hand.fire2_n = opening_rows[k].fire2_n;
			hand.servo_move = opening_rows[k].servo_move;
			send_tick(t, opening_rows[k].typed, hand);
			clock_ms = t.now;
		end

		// Ground and rising churn with an apogee out of reach, so aborts and fresh
		// launches repeat. Jumps of the clock while on the ground move the launch
		// stamp around the whole time range.
		step_max = 15;
		jump_pct = 10;
		load_setting($urandom_range(600, 0) - 300, $urandom_range(400, 0) - 200,
			$urandom_range(40, 0), 32'hF000_0000 | $urandom_range(65535, 0),
			32'hFFFF_FFFF, $urandom_range(30, 1), $urandom_range(30, 1),
			$urandom_range(30, 1));
		fly(100);

		// Lowest launch level with an abort window open from zero: every ground tick
		// launches, and rising aborts whenever the altitude sits at the floor.
		load_setting(ALT_MIN, ALT_MAX, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd0, 32'd0, 32'd0);
		fly(60);

		// Highest launch level: only the ceiling altitude launches, and once the
		// window opens every altitude aborts.
		load_setting(ALT_MAX, ALT_MIN, $urandom_range(20, 0),
			32'h8000_0000 + $urandom_range(32'h7FFF_FFFE, 0), 32'hFFFF_FFFF,
			$urandom_range(30, 1), $urandom_range(30, 1), $urandom_range(30, 1));
		fly(60);

		// Crossed window: the abort start lies past the apogee time, so the flight
		// goes up to apogee and on into detach. The pin is dropped at every confirm
		// check, so the detach sequence keeps falling back to its start.
		step_max = 10;
		jump_pct = 5;
		confirm_pin_pct = 0;
		load_setting($urandom_range(200, 0) - 100, $urandom_range(200, 0) - 100,
			$urandom_range(100, 60), $urandom_range(59, 20), 32'hFFFF_FFFF,
			$urandom_range(30, 1), $urandom_range(40, 1), $urandom_range(40, 1));
		fly(120);

		// Detach is let through now, with delays that are often zero. The deploy
		// level sits at the floor, so falling lasts until the altitude hits it.
		confirm_pin_pct = 70;
		load_setting($urandom_range(200, 0) - 100, ALT_MIN, $urandom_range(100, 60),
			$urandom_range(59, 20), 32'hFFFF_FFFF, maybe_zero(40), maybe_zero(40),
			maybe_zero(40));
		fly(100);

		// A short end time ends touch ground; afterwards the block is frozen and the
		// clock jumps anywhere, so the reported flight time wraps.
		jump_any = 1'b1;
		jump_pct = 25;
		load_setting($urandom_range(600, 0) - 300, $urandom_range(600, 0) - 300,
			$urandom_range(100, 60), $urandom_range(59, 20), $urandom_range(2000, 0),
			$urandom_range(30, 0), $urandom_range(30, 0), $urandom_range(30, 0));
		fly(60);

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d tick items under %0d register settings after reset,",
			ticks_sent, settings_used + 1);
		$display("with %0d aborts to ground, %0d servo pulses, deepest phase %0d; %0d checked.",
			aborts_seen, servo_pulses, deepest_phase, results_checked);
		if (errors == 0 && telemetry_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Result side: the ready line follows a mode that is drawn anew at random intervals
	// (always ready, mostly ready, mostly stalled). Once, after enough results, it holds
	// off for a long stretch while the sender keeps offering, so the pipe backs up.
	initial begin : result_stall
		int mode;
		int stretch;
		bit long_done;
		long_done = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(2, 0);
			stretch = $urandom_range(80, 10);
			repeat (stretch) begin
				@(posedge clk);
				if (!long_done && results_checked >= HOLD_AFTER) begin
					m_tready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
					long_done = 1'b1;
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= ($urandom_range(99, 0) < 75);
						default: m_tready <= ($urandom_range(99, 0) < 25);
					endcase
				end
			end
		end
	end

	// Compares every result item taken from the block with the oldest expectation.
	always @(posedge clk) begin : telemetry_check
		telemetry_t got;
		telemetry_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[TELEM_BITS-1:0];
			if (telemetry_due.size() == 0) begin
				$error("result item with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				want = telemetry_due.pop_front();
				results_checked++;
				if (got.phase !== want.phase) begin
					$error("phase: expected %0d, got %0d", want.phase, got.phase);
					errors++;
				end
				if (got.flight_ms !== want.flight_ms) begin
					$error("flight_ms: expected %0d, got %0d", want.flight_ms, got.flight_ms);
					errors++;
				end
				if (got.fire1_n !== want.fire1_n) begin
					$error("fire1_n: expected %b, got %b", want.fire1_n, got.fire1_n);
					errors++;
				end
				if (got.fire2_n !== want.fire2_n) begin
					$error("fire2_n: expected %b, got %b", want.fire2_n, got.fire2_n);
					errors++;
				end
				if (got.servo_move !== want.servo_move) begin
					$error("servo_move: expected %b, got %b", want.servo_move,
						got.servo_move);
					errors++;
				end
				if (m_tdata[OUT_W-1:TELEM_BITS] !== '0) begin
					$error("zero fill: expected 0, got %b", m_tdata[OUT_W-1:TELEM_BITS]);
					errors++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	int cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", cycles,
				telemetry_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
